// File: hdl/cube_tld_pkg.sv
// Shared constants, codes and types of the cube timer line decoder.
`default_nettype none

package cube_tld_pkg;

	// Line store geometry
	localparam int LINE_BYTES = 10;
	localparam int FILL_W     = $clog2(LINE_BYTES);

	// Idle tick counter, saturating
	localparam int              IDLE_W   = 17;
	localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

	localparam int               TIMEOUT_W     = 16;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

	// Characters
	localparam logic [7:0] CHR_CR    = 8'd13;
	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_I     = 8'h49;
	localparam logic [7:0] CHR_ZERO  = 8'h30;

	// Time decode: sum of byte*weight, then remove 48*(sum of weights), mod 2^32
	localparam int          TSUM_W     = 25;
	localparam logic [TSUM_W-1:0] W_MIN    = 25'd60000;
	localparam logic [TSUM_W-1:0] W_TENSEC = 25'd10000;
	localparam logic [TSUM_W-1:0] W_SEC    = 25'd1000;
	localparam logic [TSUM_W-1:0] W_HUND   = 25'd100;
	localparam logic [TSUM_W-1:0] W_TENTH  = 25'd10;
	localparam logic [TSUM_W-1:0] W_MS     = 25'd1;
	localparam logic [31:0]       DIGIT_BIAS = 32'd3413328;

	typedef enum logic [2:0] {
		EV_CONNECT    = 3'd0,
		EV_START      = 3'd1,
		EV_STOP       = 3'd2,
		EV_RESET      = 3'd3,
		EV_DISCONNECT = 3'd4
	} event_t;

	typedef struct packed {
		event_t      event_code;
		logic [31:0] time_ms;
		logic [1:0]  link_state;
		logic        last_event;
	} result_t;

	// Up to two results caused by one input word
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} result_pair_t;

endpackage

`default_nettype wire

// File: hdl/cube_tld_core.sv
// Line store, link state machine, idle counter and time decode.
`default_nettype none

module cube_tld_core (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   step,
	input  wire logic                                   cmd,
	input  wire logic [7:0]                             rx_byte,
	input  wire logic                                   cfg_we,
	input  wire logic [cube_tld_pkg::TIMEOUT_W-1:0]     cfg_data,
	output cube_tld_pkg::result_pair_t                  pair
);

	typedef enum logic [1:0] {
		PH_DISC = 2'd0,
		PH_WAIT = 2'd1,
		PH_RUN  = 2'd2,
		PH_STOP = 2'd3
	} phase_t;

	localparam int LB = cube_tld_pkg::LINE_BYTES;
	localparam int FW = cube_tld_pkg::FILL_W;
	localparam int IW = cube_tld_pkg::IDLE_W;
	localparam int TW = cube_tld_pkg::TSUM_W;

	logic [7:0]                           store_q [LB];
	logic [FW-1:0]                        fill_q;
	phase_t                               phase_q;
	logic [IW-1:0]                        idle_q;
	logic [cube_tld_pkg::TIMEOUT_W-1:0]   timeout_q;

	logic [7:0]    eff [7];
	logic          is_idle;
	logic [TW-1:0] tsum;
	logic [31:0]   time_val;
	logic [IW-1:0] idle_inc;
	logic          tick_disc;
	logic          is_cr;
	phase_t        ph_line;

	// Bytes 0..6 as seen after the terminator write
	always_comb begin
		for (int i = 0; i < 7; i++) begin
			eff[i] = (fill_q == FW'(i)) ? 8'd0 : store_q[i];
		end
	end

	assign is_idle = (eff[0] == cube_tld_pkg::CHR_I) &&
		(eff[1] == cube_tld_pkg::CHR_ZERO) && (eff[2] == cube_tld_pkg::CHR_ZERO) &&
		(eff[3] == cube_tld_pkg::CHR_ZERO) && (eff[4] == cube_tld_pkg::CHR_ZERO) &&
		(eff[5] == cube_tld_pkg::CHR_ZERO) && (eff[6] == cube_tld_pkg::CHR_ZERO);

	assign tsum = TW'(eff[1]) * cube_tld_pkg::W_MIN + TW'(eff[2]) * cube_tld_pkg::W_TENSEC
		+ TW'(eff[3]) * cube_tld_pkg::W_SEC + TW'(eff[4]) * cube_tld_pkg::W_HUND
		+ TW'(eff[5]) * cube_tld_pkg::W_TENTH + TW'(eff[6]) * cube_tld_pkg::W_MS;
	assign time_val = 32'(tsum) - cube_tld_pkg::DIGIT_BIAS;

	assign idle_inc  = (idle_q == cube_tld_pkg::IDLE_MAX) ? idle_q : idle_q + IW'(1);
	assign tick_disc = (phase_q != PH_DISC) && (idle_inc > IW'(timeout_q));
	assign is_cr     = (rx_byte == cube_tld_pkg::CHR_CR);

	// Result selection; at most two events fire on one line
	always_comb begin
		phase_t ph;
		logic [1:0] n;
		ph   = phase_q;
		n    = 2'd0;
		pair = '0;
		if (cmd) begin
			if (tick_disc) begin
				pair.r0 = '{cube_tld_pkg::EV_DISCONNECT, 32'd0, PH_DISC, 1'b1};
				n = 2'd1;
			end
		end else if (is_cr) begin
			if (ph == PH_DISC) begin
				ph = is_idle ? PH_STOP : PH_WAIT;
				pair.r0 = '{cube_tld_pkg::EV_CONNECT, 32'd0, ph, 1'b0};
				n = 2'd1;
			end
			if ((ph == PH_WAIT) && (eff[0] == cube_tld_pkg::CHR_SPACE)) begin
				ph = PH_RUN;
				if (n == 2'd0) pair.r0 = '{cube_tld_pkg::EV_START, 32'd0, ph, 1'b0};
				else pair.r1 = '{cube_tld_pkg::EV_START, 32'd0, ph, 1'b0};
				n = n + 2'd1;
			end
			if ((ph == PH_RUN) && (eff[0] == cube_tld_pkg::CHR_I)) begin
				ph = PH_STOP;
				if (n == 2'd0) pair.r0 = '{cube_tld_pkg::EV_STOP, time_val, ph, 1'b0};
				else pair.r1 = '{cube_tld_pkg::EV_STOP, time_val, ph, 1'b0};
				n = n + 2'd1;
			end
			if ((ph == PH_STOP) && is_idle) begin
				ph = PH_WAIT;
				if (n == 2'd0) pair.r0 = '{cube_tld_pkg::EV_RESET, 32'd0, ph, 1'b0};
				else pair.r1 = '{cube_tld_pkg::EV_RESET, 32'd0, ph, 1'b0};
				n = n + 2'd1;
			end
			if (n == 2'd1) pair.r0.last_event = 1'b1;
			if (n == 2'd2) pair.r1.last_event = 1'b1;
		end
		pair.count = n;
		ph_line    = ph;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LB; i++) store_q[i] <= 8'd0;
			fill_q    <= '0;
			phase_q   <= PH_DISC;
			idle_q    <= '0;
			timeout_q <= cube_tld_pkg::TIMEOUT_RESET;
		end else begin
			if (cfg_we) timeout_q <= cfg_data;
			if (step) begin
				if (cmd) begin
					idle_q <= idle_inc;
					if (tick_disc) phase_q <= PH_DISC;
				end else if (is_cr) begin
					store_q[fill_q] <= 8'd0;
					phase_q <= ph_line;
					idle_q  <= '0;
					fill_q  <= '0;
				end else if (fill_q < FW'(LB - 1)) begin
					store_q[fill_q] <= rx_byte;
					fill_q <= fill_q + FW'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/cube_tld_out_buf.sv
// Two-entry result buffer that drains one result word per cycle while out_ready is high.
`default_nettype none

module cube_tld_out_buf (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        load,
	input  wire cube_tld_pkg::result_pair_t  pair,
	input  wire logic                        out_ready,
	output logic                             out_valid,
	output cube_tld_pkg::result_t            head,
	output logic                             free
);

	logic [1:0]            cnt_q;
	cube_tld_pkg::result_t slot0_q;
	cube_tld_pkg::result_t slot1_q;
	logic                  pop;

	assign out_valid = (cnt_q != 2'd0);
	assign head      = slot0_q;
	assign pop       = out_valid && out_ready;
	// room for a full pair once this cycle's pop is counted
	assign free      = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= pair.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= pair.r0;
			slot1_q <= pair.r1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

endmodule

`default_nettype wire

// File: hdl/cube_timer_line_decoder_unit.sv
// Top level of the cube timer line decoder: input register, core and result buffer.
`default_nettype none

// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    tuser: command; tdata: rx_byte
// m_*       out  m_tvalid/m_tready    tuser: event_code; tdata: time_ms, link_state; tlast
// cfg_*     in   cfg_valid/cfg_ready  cfg_data: timeout_ms
//
// One input word per cycle while the result buffer can take the held word. A word is
// registered in the input register, then the core evaluates it in a single pass and
// loads its 0..2 results into the result buffer, which drives m_tvalid. A line that
// yields two events holds the next word in the input register while the buffer drains.
// Reset (arst_n low) clears the line store, link state and idle count and sets the timeout to 1000.
// Input stalls only when the input register holds a word the buffer cannot take.
module cube_timer_line_decoder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input words
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire logic        s_tuser,   // [0] command: 0 byte, 1 ms tick
	// result words
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [31:0] time_ms, [33:32] link_state, [39:34] zero
	output logic [2:0]       m_tuser,   // [2:0] event_code
	output logic             m_tlast,   // last_event
	// configuration
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data   // timeout_ms
);

	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] byte_s1;
	logic       buf_free;
	logic       advance;

	cube_tld_pkg::result_pair_t pair;
	cube_tld_pkg::result_t      head;

	// Core updates its line and link state exactly when a word moves into the buffer
	assign advance   = valid_s1 && buf_free;
	assign s_tready  = !valid_s1 || buf_free;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	cube_tld_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.cmd      (cmd_s1),
		.rx_byte  (byte_s1),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.pair     (pair)
	);

	cube_tld_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.pair      (pair),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.head      (head),
		.free      (buf_free)
	);

	assign m_tuser = head.event_code;
	assign m_tdata = {6'd0, head.link_state, head.time_ms};
	assign m_tlast = head.last_event;

	// Only a stop carries a time
	a_time_only_on_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != cube_tld_pkg::EV_STOP)) |-> (m_tdata[31:0] == 32'd0))
		else $error("time_ms nonzero on a non-stop event");

	// Disconnect is a lone event and leaves the link disconnected
	a_disc_state: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == cube_tld_pkg::EV_DISCONNECT))
			|-> (m_tlast && (m_tdata[33:32] == 2'd0)))
		else $error("disconnect event with wrong state or not last");

	// Input stalls only when a word waits and results are backed up
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_tvalid))
		else $error("input stalled without a pending word and pending result");

	// A non-final result is always followed by the rest of its group
	a_group_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
		else $error("result group broken after non-final word");

endmodule

`default_nettype wire
